// ----- rtl/aces_tonemap_gamma_encode_macros.svh -----
// assertion macros used by the tone mapping top level
`ifndef ACES_TONEMAP_GAMMA_ENCODE_MACROS_SVH
`define ACES_TONEMAP_GAMMA_ENCODE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define ATGE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tone map pipeline check failed");

// next-cycle implication, clocked on clk, off during reset
`define ATGE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tone map pipeline check failed");

`endif

// ----- rtl/atge_pkg.sv -----
// types, constants and the gamma threshold builder for the tone mapper
package atge_pkg;

	localparam int HdrWidth  = 20;
	localparam int RgbWidth  = 8;
	localparam int GainWidth = 16;
	localparam logic [GainWidth-1:0] GainReset = 16'd4096;
	localparam logic [HdrWidth-1:0]  FieldMax  = 20'hFFFFF;
	localparam int SearchSteps = 8;
	localparam int ThrWidth    = 16;

	typedef struct packed {
		logic [HdrWidth-1:0] hdr_red;
		logic [HdrWidth-1:0] hdr_green;
		logic [HdrWidth-1:0] hdr_blue;
	} hdr_pixel_t;

	typedef struct packed {
		logic [RgbWidth-1:0] out_red;
		logic [RgbWidth-1:0] out_green;
		logic [RgbWidth-1:0] out_blue;
	} rgb_pixel_t;

	typedef logic [255:0][ThrWidth-1:0] thr_table_t;

	// exposure, round, coefficients, products, divider setup, divider, index, search
	function automatic int atge_latency(int frac_bits);
		return frac_bits + 7 + SearchSteps;
	endfunction

	// entry k: smallest table index whose encoded value reaches k, i.e.
	// i^5 * 510^11 >= (2k-1)^11 * 2^(5g); past the top if none does
	function automatic thr_table_t gamma_thresholds(int g);
		thr_table_t res;
		logic [191:0] base, rhs, lhs;
		int lo, hi, mid, k, j;
		res = '0;
		base = 192'd1;
		for (j = 0; j < 11; j++) base = base * 192'd510;
		for (k = 1; k < 256; k++) begin
			rhs = 192'd1;
			for (j = 0; j < 11; j++) rhs = rhs * 192'(2 * k - 1);
			rhs = rhs << (5 * g);
			lo = 0;
			hi = (1 << g) + 1;
			while (lo < hi) begin
				mid = (lo + hi) >> 1;
				lhs = base;
				for (j = 0; j < 5; j++) lhs = lhs * 192'(mid);
				if (lhs >= rhs) hi = mid;
				else lo = mid + 1;
			end
			res[k] = ThrWidth'(lo);
		end
		return res;
	endfunction

endpackage

// ----- rtl/aces_tonemap_gamma_encode.sv -----
// top level: aces filmic tone mapping with gamma encode, one pixel per clock unless stalled
//  channel | handshake            | payload
//  hdr     | hdr_valid, hdr_stall | hdr_pixel (three 20-bit U8.12 channels)
//  rgb     | rgb_valid, rgb_stall | rgb_pixel (three 8-bit channels)
//  cfg     | cfg_we               | cfg_data (exposure gain, U4.12)
// a pixel is accepted every cycle unless the output stalls; the pipeline holds
// the bit-per-stage restoring divider of the tone curve and the 8-step search
// of the gamma thresholds
// a stalled result freezes the whole pipeline, so hdr_stall = rgb_valid && rgb_stall
// reset clears the valid bits and returns the gain to 1.0
`include "aces_tonemap_gamma_encode_macros.svh"
module aces_tonemap_gamma_encode #(
	parameter int FRAC_BITS        = 12,
	parameter int GAMMA_TABLE_BITS = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [atge_pkg::GainWidth-1:0] cfg_data,
	input  logic                           hdr_valid,
	output logic                           hdr_stall,
	input  atge_pkg::hdr_pixel_t           hdr_pixel,
	output logic                           rgb_valid,
	input  logic                           rgb_stall,
	output atge_pkg::rgb_pixel_t           rgb_pixel
);
	import atge_pkg::*;

	localparam int Lat = atge_latency(FRAC_BITS);

	logic [GainWidth-1:0] gain_q;
	logic [Lat-1:0]       valid_s;
	logic                 en;

	assign en        = !(rgb_valid && rgb_stall);
	assign hdr_stall = !en;
	assign rgb_valid = valid_s[Lat-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GainReset;
			valid_s <= '0;
		end else begin
			if (cfg_we) gain_q <= cfg_data;
			if (en) valid_s <= {valid_s[Lat-2:0], hdr_valid};
		end
	end

	atge_channel #(.FRAC_BITS(FRAC_BITS), .GAMMA_TABLE_BITS(GAMMA_TABLE_BITS)) u_red (
		.clk(clk), .en(en), .gain(gain_q), .x(hdr_pixel.hdr_red), .y(rgb_pixel.out_red)
	);
	atge_channel #(.FRAC_BITS(FRAC_BITS), .GAMMA_TABLE_BITS(GAMMA_TABLE_BITS)) u_green (
		.clk(clk), .en(en), .gain(gain_q), .x(hdr_pixel.hdr_green), .y(rgb_pixel.out_green)
	);
	atge_channel #(.FRAC_BITS(FRAC_BITS), .GAMMA_TABLE_BITS(GAMMA_TABLE_BITS)) u_blue (
		.clk(clk), .en(en), .gain(gain_q), .x(hdr_pixel.hdr_blue), .y(rgb_pixel.out_blue)
	);

	// an empty output never holds back the input
	`ATGE_ASSERT_IMP(a_empty_no_stall, !rgb_valid, !hdr_stall)
	// an accepted transaction lands in the first stage
	`ATGE_ASSERT_NXT(a_accept_enters, hdr_valid && !hdr_stall, valid_s[0])
	// a frozen pipeline keeps its occupancy
	`ATGE_ASSERT_NXT(a_freeze_holds, hdr_stall, $stable(valid_s))

endmodule

// ----- rtl/atge_channel.sv -----
// one colour channel: exposure, aces curve, divider and gamma search pipeline
module atge_channel #(
	parameter int FRAC_BITS        = 12,
	parameter int GAMMA_TABLE_BITS = 12
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic [atge_pkg::GainWidth-1:0]  gain,
	input  logic [atge_pkg::HdrWidth-1:0]   x,
	output logic [atge_pkg::RgbWidth-1:0]   y
);
	import atge_pkg::*;

	localparam int F   = FRAC_BITS;
	localparam int G   = GAMMA_TABLE_BITS;
	localparam int PW  = HdrWidth + GainWidth;
	localparam int AW  = 30;
	localparam int NW  = 50;
	localparam int NNW = NW + F + 1;
	localparam int TW  = F + 1;
	localparam int IW  = G + 1;
	localparam logic [AW-1:0] Coef3S  = AW'(3) << F;
	localparam logic [AW-1:0] Coef59S = AW'(59) << F;
	localparam logic [NW-1:0] Coef14S2 = NW'(14) << (2 * F);
	localparam logic [TW-1:0] One     = TW'(1) << F;
	localparam thr_table_t GammaThr = gamma_thresholds(G);

	logic [PW-1:0]       prod_s1;
	logic [HdrWidth-1:0] v_s2, v_s3;
	logic [AW-1:0]       a_s3, b_s3;
	logic [NW-1:0]       n_s4, d_s4;
	logic [PW:0]         rnd;
	logic [PW:0]         shifted;
	logic [NNW-1:0]      num;

	// divider stage 0 is the setup register, stage F+1 holds the quotient
	logic [NW-1:0] r_s   [0:F+1];
	logic [NW-1:0] dv_s  [0:F+1];
	logic [F:0]    lo_s  [0:F+1];
	logic [TW-1:0] q_s   [0:F+1];
	logic          clp_s [0:F+1];

	logic [TW-1:0] t;
	logic [IW-1:0] idx;
	logic [IW-1:0] idx_s [0:SearchSteps];
	logic [7:0]    k_s   [0:SearchSteps];

	assign rnd     = {1'b0, prod_s1} + ((PW+1)'(1) << (F - 1));
	assign shifted = rnd >> F;
	assign num     = {n_s4, {(F+1){1'b0}}} >> 1;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PW'(x) * PW'(gain);
			v_s2    <= (shifted > (PW+1)'(FieldMax)) ? FieldMax : shifted[HdrWidth-1:0];
			a_s3    <= AW'(251) * AW'(v_s2) + Coef3S;
			b_s3    <= AW'(243) * AW'(v_s2) + Coef59S;
			v_s3    <= v_s2;
			n_s4    <= NW'(v_s3) * NW'(a_s3);
			d_s4    <= NW'(v_s3) * NW'(b_s3) + Coef14S2;
		end
	end

	// numerator n*S + d/2, first remainder is its top part
	logic [NNW-1:0] nfull;
	assign nfull = num + NNW'(d_s4 >> 1);

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]   <= NW'(nfull >> (F + 1));
			lo_s[0]  <= nfull[F:0];
			dv_s[0]  <= d_s4;
			q_s[0]   <= '0;
			clp_s[0] <= (n_s4 >= d_s4);
		end
	end

	for (genvar j = 0; j <= F; j++) begin : g_div
		logic [NW:0] r_in;
		logic        take;
		assign r_in = {r_s[j], lo_s[j][F-j]};
		assign take = (r_in >= {1'b0, dv_s[j]});
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[j+1]   <= NW'(take ? r_in - {1'b0, dv_s[j]} : r_in);
				lo_s[j+1]  <= lo_s[j];
				dv_s[j+1]  <= dv_s[j];
				q_s[j+1]   <= {q_s[j][TW-2:0], take};
				clp_s[j+1] <= clp_s[j];
			end
		end
		// remainder stays below d, so the top bit of r_in is zero when it is kept
	end

	assign t = clp_s[F+1] ? One : q_s[F+1];

	if (G >= F) begin : g_widen
		assign idx = IW'(t) << (G - F);
	end else begin : g_narrow
		logic [TW:0] tr;
		assign tr  = {1'b0, t} + ((TW+1)'(1) << (F - G - 1));
		assign idx = IW'(tr >> (F - G));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s[0] <= idx;
			k_s[0]   <= '0;
		end
	end

	// binary search of the monotone threshold list, one bit a stage
	for (genvar m = 0; m < SearchSteps; m++) begin : g_srch
		logic [7:0] cand;
		assign cand = k_s[m] | (8'd1 << (SearchSteps - 1 - m));
		always_ff @(posedge clk) begin
			if (en) begin
				idx_s[m+1] <= idx_s[m];
				k_s[m+1]   <= (GammaThr[cand] <= ThrWidth'(idx_s[m])) ? cand : k_s[m];
			end
		end
	end

	assign y = k_s[SearchSteps];

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for the aces tone mapper with gamma encode
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import atge_pkg::*;

	localparam int Frac      = 12;
	localparam int TableBits = 12;
	localparam int Latency   = Frac + 15;
	localparam int RomSize   = (1 << TableBits) + 1;

	// predicts the encoded pixel and holds the pixels still to come out
	class tonemap_scoreboard;
		logic [GainWidth-1:0] gain;
		logic [RgbWidth-1:0]  rom[RomSize];
		rgb_pixel_t           pending[$];
		int                   errors;

		function new();
			logic [191:0] base, lhs, thr[256];
			int i, j, k;
			gain = GainReset;
			errors = 0;
			base = 192'd1;
			for (j = 0; j < 11; j++) base = base * 192'd510;
			for (k = 1; k < 256; k++) begin
				thr[k] = 192'd1;
				for (j = 0; j < 11; j++) thr[k] = thr[k] * 192'(2 * k - 1);
				thr[k] = thr[k] << (5 * TableBits);
			end
			k = 0;
			for (i = 0; i < RomSize; i++) begin
				lhs = base;
				for (j = 0; j < 5; j++) lhs = lhs * 192'(i);
				while (k < 255 && lhs >= thr[k + 1]) k++;
				rom[i] = RgbWidth'(k);
			end
		endfunction

		function logic [RgbWidth-1:0] encode(logic [HdrWidth-1:0] x);
			longint unsigned v, n, d, s, t;
			s = 64'd1 << Frac;
			v = (longint'(x) * longint'(gain) + (s >> 1)) >> Frac;
			if (v > FieldMax) v = FieldMax;
			n = v * (251 * v + 3 * s);
			d = v * (243 * v + 59 * s) + 14 * s * s;
			if (n >= d) t = s;
			else t = (n * s + d / 2) / d;
			// frac and table widths match, so t is the index
			if (t >= RomSize) t = RomSize - 1;
			return rom[t];
		endfunction

		function void note_pixel(hdr_pixel_t p);
			rgb_pixel_t e;
			e.out_red   = encode(p.hdr_red);
			e.out_green = encode(p.hdr_green);
			e.out_blue  = encode(p.hdr_blue);
			pending.insert(pending.size(), e);
		endfunction

		function void check_pixel(rgb_pixel_t a);
			rgb_pixel_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected rgb transaction %h", $time, a);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.out_red !== e.out_red)
				$display("%0t: red expected %0d actual %0d", $time, e.out_red, a.out_red);
			if (a.out_green !== e.out_green)
				$display("%0t: green expected %0d actual %0d", $time, e.out_green,
					a.out_green);
			if (a.out_blue !== e.out_blue)
				$display("%0t: blue expected %0d actual %0d", $time, e.out_blue, a.out_blue);
			if (a !== e) errors++;
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [GainWidth-1:0] cfg_data;
	logic                 hdr_valid;
	logic                 hdr_stall;
	hdr_pixel_t           hdr_pixel;
	logic                 rgb_valid;
	logic                 rgb_stall;
	rgb_pixel_t           rgb_pixel;
	logic                 calm;

	tonemap_scoreboard sb = new();

	aces_tonemap_gamma_encode #(
		.FRAC_BITS(Frac),
		.GAMMA_TABLE_BITS(TableBits)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.hdr_valid(hdr_valid),
		.hdr_stall(hdr_stall),
		.hdr_pixel(hdr_pixel),
		.rgb_valid(rgb_valid),
		.rgb_stall(rgb_stall),
		.rgb_pixel(rgb_pixel)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && hdr_valid && !hdr_stall) sb.note_pixel(hdr_pixel);
		if (arst_n && rgb_valid && !rgb_stall) sb.check_pixel(rgb_pixel);
	end

	// receiver back-pressure: mostly short stalls, now and then a long one
	always @(posedge clk) begin
		if (calm || $urandom_range(0, 2) != 0) begin
			rgb_stall <= 1'b0;
		end else begin
			rgb_stall <= 1'b1;
			repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(1, 2))
				@(posedge clk);
			rgb_stall <= 1'b0;
		end
	end

	function automatic logic [HdrWidth-1:0] rand_channel();
		int w;
		w = $urandom_range(1, HdrWidth);
		return HdrWidth'($urandom) & HdrWidth'((64'd1 << w) - 1);
	endfunction

	task automatic send_pixel(hdr_pixel_t p);
		hdr_valid <= 1'b1;
		hdr_pixel <= p;
		do @(posedge clk); while (!(hdr_valid && !hdr_stall));
		if (!calm && $urandom_range(0, 3) == 0) begin
			hdr_valid <= 1'b0;
			repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 3))
				@(posedge clk);
		end
	endtask

	task automatic drain();
		hdr_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (Latency + 5) @(posedge clk);
	endtask

	task automatic write_gain(logic [GainWidth-1:0] g);
		drain();
		cfg_we   <= 1'b1;
		cfg_data <= g;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.gain = g;
		@(posedge clk);
	endtask

	task automatic send_random(int count);
		hdr_pixel_t p;
		repeat (count) begin
			p.hdr_red   = rand_channel();
			p.hdr_green = rand_channel();
			p.hdr_blue  = rand_channel();
			send_pixel(p);
		end
	endtask

	initial begin
		logic [GainWidth-1:0] gains[10];
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_data  = '0;
		hdr_valid = 1'b0;
		hdr_pixel = '0;
		rgb_stall = 1'b0;
		calm      = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pixels at the reset gain, then at gains 0, 0xFFFF and 1: zero, saturation, clamp, small values
		send_pixel('{20'd0, 20'd0, 20'd0});
		send_pixel('{FieldMax, FieldMax, FieldMax});
		send_pixel('{20'd1, 20'd2, 20'd3});
		send_pixel('{20'd4096, 20'd2048, 20'd40960});
		send_pixel('{20'hAAAAA, 20'h55555, 20'h00FFF});
		send_pixel('{20'h55555, 20'hAAAAA, 20'hFF000});
		send_pixel('{20'd100, 20'd409, 20'd8192});
		write_gain(16'd0);
		send_pixel('{FieldMax, 20'd4096, 20'd1});
		write_gain(16'hFFFF);
		send_pixel('{FieldMax, 20'd1, 20'd4096});
		send_pixel('{20'd16, 20'd64, 20'd256});
		write_gain(16'd1);
		send_pixel('{FieldMax, 20'd2048, 20'd1});

		gains = '{GainReset, 16'hFFFF, 16'd0, 16'd1, 16'd2048, 16'd512, 16'd20000,
			16'h8000, 16'h1234, GainReset};
		foreach (gains[i]) begin
			write_gain(i == 5 ? GainWidth'($urandom) : gains[i]);
			calm = (i % 3 == 2);
			send_random(110);
		end
		calm = 1'b0;
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

endmodule
